// File: rtl/wcps_pkg.sv
`default_nettype none

package wcps_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING_COLOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUND_COLOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 3'd4;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam int HIT_FRAC_BITS = 16;
    localparam int TEX_PITCH_BITS = 6;

    typedef enum logic [1:0] {
        REGION_CEILING = 2'd0,
        REGION_WALL = 2'd1,
        REGION_FLOOR = 2'd2
    } region_t;

    // carried alongside the wall height divider
    typedef struct packed {
        logic        kind;
        logic [11:0] row;
        logic [5:0]  tcol;
        logic [11:0] laddr;
        logic [31:0] lval;
    } side1_t;

    // carried alongside the texel row divider
    typedef struct packed {
        logic        kind;
        region_t     region;
        logic [5:0]  tcol;
        logic        span_zero;
        logic        shade_ok;
        logic [11:0] laddr;
        logic [31:0] lval;
    } side2_t;

endpackage

`default_nettype wire

// File: rtl/wcps_if.sv
`default_nettype none

interface wcps_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [11:0] row;
    logic [23:0] wall_dist;
    logic [23:0] hit_x;
    logic [23:0] hit_y;
    logic        side;
    logic [11:0] load_addr;
    logic [31:0] load_value;

    modport source (output valid, kind, row, wall_dist, hit_x, hit_y, side,
                    load_addr, load_value, input ready);
    modport sink (input valid, kind, row, wall_dist, hit_x, hit_y, side,
                  load_addr, load_value, output ready);
endinterface

interface wcps_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] color;
    logic [1:0]  region;

    modport source (output valid, color, region, input ready);
    modport sink (input valid, color, region, output ready);
endinterface

`default_nettype wire

// File: rtl/wall_column_pixel_shader.sv
// Channel   | Role   | Payload
// ----------+--------+--------------------------------------------------------
// item      | sink   | kind, row, wall_dist, hit_x, hit_y, side, load_addr,
//           |        | load_value
// result    | source | color, region (one per pixel transaction, none per load)
// cfg_*     | write  | cfg_we, cfg_index, cfg_data
//
// One transaction per cycle while the pipeline is not frozen by a stalled result.
// The path from item to result runs through the wall height divider
// (12 + DIST_FRAC_BITS stages), the region stage, the multiply stage, the 8-stage
// texel row / shade dividers, the texture RAM read register and the result register.
// Reset clears valid bits and sets the config defaults, not the texture store.
// A stalled result freezes the pipeline unless the slot ahead of it is empty.
`default_nettype none

module wall_column_pixel_shader #(
    parameter int TEX_SIZE = 4096,
    parameter int DIST_FRAC_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [wcps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wcps_pkg::CFG_DATA_W-1:0] cfg_data,
    wcps_in_if.sink                             item,
    wcps_out_if.source                          result
);

    import wcps_pkg::*;

    localparam int WSW = 12 + DIST_FRAC_BITS;
    localparam int SXW = WSW + 2;
    localparam int AW  = $clog2(TEX_SIZE);
    localparam int AXW = (AW > 12) ? AW : 12;

    // configuration
    logic [11:0] height_reg;
    logic [31:0] ceil_reg;
    logic [31:0] ground_reg;
    logic [6:0]  tw_reg;
    logic [6:0]  th_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= 12'd512;
            ceil_reg   <= '0;
            ground_reg <= '0;
            tw_reg     <= 7'd64;
            th_reg     <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCREEN_HEIGHT:  height_reg <= cfg_data[11:0];
                CFG_CEILING_COLOR:  ceil_reg   <= cfg_data;
                CFG_GROUND_COLOR:   ground_reg <= cfg_data;
                CFG_TEXTURE_WIDTH:  tw_reg     <= cfg_data[6:0];
                CFG_TEXTURE_HEIGHT: th_reg     <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [11:0] h_eff;
    logic [6:0]  tw_eff;
    logic [6:0]  th_eff;

    assign h_eff  = (height_reg < 12'd2) ? 12'd2 : height_reg;
    assign tw_eff = (tw_reg == 7'd0) ? 7'd1 : ((tw_reg > 7'd64) ? 7'd64 : tw_reg);
    assign th_eff = (th_reg == 7'd0) ? 7'd1 : ((th_reg > 7'd64) ? 7'd64 : th_reg);

    // flow control
    logic out_v_reg;
    logic d_v_reg;
    logic out_upd;
    logic adv;

    assign out_upd    = !out_v_reg || result.ready;
    assign adv        = out_upd || !d_v_reg;
    assign item.ready = adv;

    // input: texture column and wall height division
    logic [23:0] hit;
    logic [15:0] frac;
    logic [22:0] tcol_prod;
    logic [6:0]  tcol_raw;
    logic [5:0]  tcol;
    side1_t      s1_in;
    side1_t      s1_out;
    logic        v1;
    logic [WSW-1:0] ws;

    assign hit       = item.side ? item.hit_y : item.hit_x;
    assign frac      = hit[15:0] + 16'h8000;
    assign tcol_prod = 23'(frac) * 23'(tw_eff);
    assign tcol_raw  = tcol_prod[22:16];
    assign tcol      = (tcol_raw > tw_eff - 7'd1) ? 6'(tw_eff - 7'd1) : tcol_raw[5:0];

    assign s1_in.kind  = item.kind;
    assign s1_in.row   = item.row;
    assign s1_in.tcol  = tcol;
    assign s1_in.laddr = item.load_addr;
    assign s1_in.lval  = item.load_value;

    wcps_div #(
        .NW (WSW),
        .DW (24),
        .QW (WSW),
        .SW ($bits(side1_t))
    ) u_div_height (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (item.valid),
        .num       ({h_eff, DIST_FRAC_BITS'(0)}),
        .den       ((item.wall_dist == 24'd0) ? 24'd1 : item.wall_dist),
        .sb_in     (s1_in),
        .out_valid (v1),
        .quo       (ws),
        .sb_out    (s1_out)
    );

    // region stage
    logic [SXW-1:0] half_x;
    logic [SXW-1:0] hw_x;
    logic [SXW-1:0] row_x;
    logic [SXW-1:0] start_x;
    logic [SXW-1:0] end_x;
    logic [SXW-1:0] diff_x;
    logic           is_ceil;
    logic           is_wall;
    logic [12:0]    two_i;
    logic [12:0]    h13;
    logic           ceil_ok;
    logic           floor_ok;
    region_t        region_next;

    assign half_x  = SXW'(h_eff >> 1);
    assign hw_x    = SXW'(ws >> 1);
    assign row_x   = SXW'(s1_out.row);
    assign start_x = half_x - hw_x;
    assign end_x   = half_x + hw_x;
    assign diff_x  = row_x - start_x;
    assign is_ceil = $signed(row_x) < $signed(start_x);
    assign is_wall = !is_ceil && ($signed(row_x) <= $signed(end_x));
    assign two_i   = {s1_out.row, 1'b0};
    assign h13     = {1'b0, h_eff};
    assign ceil_ok  = two_i < h13;
    assign floor_ok = (two_i > h13) && (s1_out.row <= h_eff);

    always_comb
    begin
        if (is_ceil)
        begin
            region_next = REGION_CEILING;
        end
        else if (is_wall)
        begin
            region_next = REGION_WALL;
        end
        else
        begin
            region_next = REGION_FLOOR;
        end
    end

    logic           a_v_reg;
    logic           a_kind_reg;
    region_t        a_region_reg;
    logic [11:0]    a_k_reg;
    logic [WSW-1:0] a_diff_reg;
    logic [WSW-1:0] a_span_reg;
    logic           a_spz_reg;
    logic           a_sok_reg;
    logic [5:0]     a_tcol_reg;
    logic [11:0]    a_laddr_reg;
    logic [31:0]    a_lval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= v1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_kind_reg   <= s1_out.kind;
            a_region_reg <= region_next;
            a_k_reg      <= is_ceil ? 12'(h13 - two_i) : 12'(two_i - h13);
            a_diff_reg   <= diff_x[WSW-1:0];
            a_span_reg   <= {ws[WSW-1:1], 1'b0};
            a_spz_reg    <= (ws[WSW-1:1] == '0);
            a_sok_reg    <= is_ceil ? ceil_ok : floor_ok;
            a_tcol_reg   <= s1_out.tcol;
            a_laddr_reg  <= s1_out.laddr;
            a_lval_reg   <= s1_out.lval;
        end
    end

    // multiply stage
    logic [31:0] shade_src;

    assign shade_src = (a_region_reg == REGION_CEILING) ? ceil_reg : ground_reg;

    logic             b_v_reg;
    logic [WSW+6:0]   b_nt_reg;
    logic [WSW-1:0]   b_span_reg;
    logic [19:0]      b_p0_reg;
    logic [19:0]      b_p1_reg;
    logic [19:0]      b_p2_reg;
    side2_t           b_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_nt_reg   <= (WSW+7)'(a_diff_reg) * (WSW+7)'(th_eff);
            b_span_reg <= a_spz_reg ? WSW'(1) : a_span_reg;
            b_p0_reg   <= 20'(shade_src[7:0]) * 20'(a_k_reg);
            b_p1_reg   <= 20'(shade_src[15:8]) * 20'(a_k_reg);
            b_p2_reg   <= 20'(shade_src[23:16]) * 20'(a_k_reg);
            b_side_reg.kind      <= a_kind_reg;
            b_side_reg.region    <= a_region_reg;
            b_side_reg.tcol      <= a_tcol_reg;
            b_side_reg.span_zero <= a_spz_reg;
            b_side_reg.shade_ok  <= a_sok_reg;
            b_side_reg.laddr     <= a_laddr_reg;
            b_side_reg.lval      <= a_lval_reg;
        end
    end

    // texel row and shade divisions
    logic       v2;
    logic [7:0] trow_q;
    logic [7:0] sq0;
    logic [7:0] sq1;
    logic [7:0] sq2;
    side2_t     s2;

    wcps_div #(
        .NW (WSW + 7),
        .DW (WSW),
        .QW (8),
        .SW ($bits(side2_t))
    ) u_div_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (b_v_reg),
        .num       (b_nt_reg),
        .den       (b_span_reg),
        .sb_in     (b_side_reg),
        .out_valid (v2),
        .quo       (trow_q),
        .sb_out    (s2)
    );

    wcps_div #(.NW(20), .DW(12), .QW(8), .SW(1)) u_div_shade0 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(b_v_reg),
        .num(b_p0_reg), .den(h_eff), .sb_in(1'b0),
        .out_valid(), .quo(sq0), .sb_out()
    );

    wcps_div #(.NW(20), .DW(12), .QW(8), .SW(1)) u_div_shade1 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(b_v_reg),
        .num(b_p1_reg), .den(h_eff), .sb_in(1'b0),
        .out_valid(), .quo(sq1), .sb_out()
    );

    wcps_div #(.NW(20), .DW(12), .QW(8), .SW(1)) u_div_shade2 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(b_v_reg),
        .num(b_p2_reg), .den(h_eff), .sb_in(1'b0),
        .out_valid(), .quo(sq2), .sb_out()
    );

    // texture access: loads write and pixels read at the same stage, in order
    logic [5:0]     trow;
    logic [11:0]    sel_addr;
    logic [AXW-1:0] sel_x;
    logic           in_range;
    logic           ram_we;
    logic [31:0]    ram_q;
    logic [31:0]    shade_color;
    logic [7:0]     top_byte;

    assign trow = s2.span_zero ? 6'd0 :
                  ((trow_q > 8'(th_eff - 7'd1)) ? 6'(th_eff - 7'd1) : trow_q[5:0]);
    assign sel_addr = (s2.kind == KIND_LOAD) ? s2.laddr
                                             : {trow, s2.tcol[TEX_PITCH_BITS-1:0]};
    assign sel_x    = AXW'(sel_addr);
    assign in_range = 32'(sel_addr) < 32'(TEX_SIZE);
    assign ram_we   = adv && v2 && (s2.kind == KIND_LOAD) && in_range;
    assign top_byte = (s2.region == REGION_CEILING) ? ceil_reg[31:24] : ground_reg[31:24];
    assign shade_color = s2.shade_ok ? {top_byte, sq2, sq1, sq0} : 32'd0;

    wcps_ram #(
        .WIDTH (32),
        .DEPTH (TEX_SIZE)
    ) u_tex (
        .clk   (clk),
        .en    (adv),
        .we    (ram_we),
        .addr  (sel_x[AW-1:0]),
        .wdata (s2.lval),
        .rdata (ram_q)
    );

    region_t     d_region_reg;
    logic [31:0] d_color_reg;
    logic        d_oob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_v_reg <= v2 && (s2.kind == KIND_PIXEL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_region_reg <= s2.region;
            d_color_reg  <= shade_color;
            d_oob_reg    <= !in_range;
        end
    end

    // result register
    logic [31:0] out_color_reg;
    region_t     out_region_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_upd)
        begin
            out_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_upd)
        begin
            out_region_reg <= d_region_reg;
            if (d_region_reg == REGION_WALL)
            begin
                out_color_reg <= d_oob_reg ? 32'd0 : ram_q;
            end
            else
            begin
                out_color_reg <= d_color_reg;
            end
        end
    end

    assign result.valid  = out_v_reg;
    assign result.color  = out_color_reg;
    assign result.region = out_region_reg;

    // checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_v_reg |-> item.ready)
        else $error("input stalled with empty result register");

    a_ceiling_top: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.region == REGION_CEILING && result.color != 32'd0)
        |-> result.color[31:24] == ceil_reg[31:24])
        else $error("ceiling top byte altered");

    a_floor_top: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.region == REGION_FLOOR && result.color != 32'd0)
        |-> result.color[31:24] == ground_reg[31:24])
        else $error("floor top byte altered");

    a_stall_blocks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (d_v_reg && out_v_reg && !result.ready) |-> !adv)
        else $error("pipeline advanced over a waiting pixel");

endmodule

`default_nettype wire

// File: rtl/wcps_ram.sv
`default_nettype none

module wcps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/wcps_div.sv
`default_nettype none

// Restoring divider, one quotient bit per stage. The caller guarantees
// num < den * 2**QW and den != 0.
module wcps_div #(
    parameter int NW = 28,
    parameter int DW = 24,
    parameter int QW = 28,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] sb_in,
    output logic               out_valid,
    output logic      [QW-1:0] quo,
    output logic      [SW-1:0] sb_out
);

    logic          v_reg  [QW];
    logic [DW-1:0] r_reg  [QW];
    logic [QW-1:0] lo_reg [QW];
    logic [QW-1:0] q_reg  [QW];
    logic [DW-1:0] d_reg  [QW];
    logic [SW-1:0] sb_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic          v_p;
        logic [DW-1:0] r_p;
        logic [QW-1:0] lo_p;
        logic [QW-1:0] q_p;
        logic [DW-1:0] d_p;
        logic [SW-1:0] sb_p;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] r_next;
        logic [QW-1:0] q_next;

        if (k == 0)
        begin : g_first
            assign v_p  = in_valid;
            assign r_p  = DW'(num >> QW);
            assign lo_p = num[QW-1:0];
            assign q_p  = '0;
            assign d_p  = den;
            assign sb_p = sb_in;
        end
        else
        begin : g_next
            assign v_p  = v_reg[k-1];
            assign r_p  = r_reg[k-1];
            assign lo_p = lo_reg[k-1];
            assign q_p  = q_reg[k-1];
            assign d_p  = d_reg[k-1];
            assign sb_p = sb_reg[k-1];
        end

        assign trial  = {r_p, lo_p[QW-1]};
        assign ge     = trial >= {1'b0, d_p};
        assign r_next = ge ? DW'(trial - {1'b0, d_p}) : DW'(trial);
        assign q_next = (q_p << 1) | QW'(ge);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]  <= r_next;
                lo_reg[k] <= lo_p << 1;
                q_reg[k]  <= q_next;
                d_reg[k]  <= d_p;
                sb_reg[k] <= sb_p;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign sb_out    = sb_reg[QW-1];

endmodule

`default_nettype wire
